@@ design/fdc_pkg.sv @@
// Shared types, codes and defaults for the floppy disk controller.
package fdc_pkg;

  localparam int DRIVES_DEF       = 2;
  localparam int TRACKS_DEF       = 77;
  localparam int SECTORS_DEF      = 32;
  localparam int SECTOR_BYTES_DEF = 137;

  // result queue depth, also the limit on items in flight
  localparam int OQ_DEPTH = 8;

  typedef enum logic [2:0] {
    OP_SELECT = 3'd0,
    OP_STATUS = 3'd1,
    OP_FUNC   = 3'd2,
    OP_SECTOR = 3'd3,
    OP_DREAD  = 3'd4,
    OP_DWRITE = 3'd5
  } op_t;

  // bit positions in the select and function bytes
  localparam int SEL_IGNORE_BIT = 7;
  localparam int FN_STEP_IN     = 0;
  localparam int FN_STEP_OUT    = 1;
  localparam int FN_WR_ENABLE   = 7;

  localparam logic [7:0] STAT_TRACK_NZ = 8'h40;
  localparam logic [7:0] NO_DRIVE_BYTE = 8'hFF;

  // request from the drive state unit to the disk image stage
  typedef struct packed {
    logic       vld;
    logic       mrd;
    logic       mwr;
    logic [7:0] rbyte;
    logic [7:0] wbyte;
  } disk_req_t;

  function automatic int wbits(input int v);
    return (v > 1) ? $clog2(v) : 1;
  endfunction

endpackage

@@ design/fdc_ram.sv @@
// Generic simple dual-port RAM with registered read (read returns old data).
module fdc_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 2,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/fdc_drv.sv @@
// Per-drive state unit: state RAM read, update, write-back and disk address.
module fdc_drv import fdc_pkg::*; #(
  parameter  int DRIVES       = DRIVES_DEF,
  parameter  int TRACKS       = TRACKS_DEF,
  parameter  int SECTORS      = SECTORS_DEF,
  parameter  int SECTOR_BYTES = SECTOR_BYTES_DEF,
  localparam int AW           = wbits(DRIVES * TRACKS * SECTORS * SECTOR_BYTES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          acc,
  input  op_t           op,
  input  logic [7:0]    data,
  input  logic [3:0]    sel,
  input  logic [AW-1:0] base,
  output disk_req_t     req,
  output logic [AW-1:0] req_addr
);

  localparam int DB    = TRACKS * SECTORS * SECTOR_BYTES;
  localparam int TSTEP = SECTORS * SECTOR_BYTES;
  localparam int OW    = wbits(DB);
  localparam int DIW   = wbits(DRIVES);

  localparam logic [6:0]    TRK_LAST = 7'(TRACKS - 1);
  localparam logic [4:0]    SEC_LAST = 5'(SECTORS - 1);
  localparam logic [4:0]    NDRV     = 5'(DRIVES);
  localparam logic [OW-1:0] TB_STEP  = OW'(TSTEP);
  localparam logic [OW-1:0] SB_STEP  = OW'(SECTOR_BYTES);
  localparam logic [OW-1:0] DB_LAST  = OW'(DB - 1);
  localparam logic [OW:0]   DB_W     = (OW+1)'(DB);

  // tbase = trk*TSTEP, sbase = sec*SECTOR_BYTES, pmod = pos mod DB, kept incrementally
  typedef struct packed {
    logic [6:0]    trk;
    logic [OW-1:0] tbase;
    logic [4:0]    sec;
    logic [OW-1:0] sbase;
    logic [15:0]   pos;
    logic [OW-1:0] pmod;
  } dstate_t;

  logic                s1_vld;
  op_t                 s1_op;
  logic [7:0]          s1_data;
  logic [DIW-1:0]      s1_idx;
  logic                s1_present;
  logic [AW-1:0]       s1_base;

  logic [DRIVES-1:0]   vld;
  logic                fwd_vld;
  logic [DIW-1:0]      fwd_idx;
  dstate_t             fwd_data;

  logic [$bits(dstate_t)-1:0] rd_raw;
  dstate_t             cur;
  dstate_t             nxt;
  logic                dwe;
  logic                mrd;
  logic                mwr;
  logic [7:0]          rb;
  logic [OW:0]         osum;
  logic [OW:0]         owrap;
  logic [AW-1:0]       addr;

  fdc_ram #(
    .WIDTH ($bits(dstate_t)),
    .DEPTH (DRIVES)
  ) u_dram (
    .clk   (clk),
    .we    (dwe),
    .waddr (s1_idx),
    .wdata (nxt),
    .raddr (sel[DIW-1:0]),
    .rdata (rd_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= acc;
    end
    s1_op      <= op;
    s1_data    <= data;
    s1_idx     <= sel[DIW-1:0];
    s1_present <= {1'b0, sel} < NDRV;
    s1_base    <= base;
  end

  // state written at the edge that issued this read is not yet in the RAM output
  always_comb begin
    if (fwd_vld && fwd_idx == s1_idx) begin
      cur = fwd_data;
    end else if (vld[s1_idx]) begin
      cur = dstate_t'(rd_raw);
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    osum  = {1'b0, cur.tbase} + {1'b0, cur.sbase} + {1'b0, cur.pmod};
    owrap = (osum >= DB_W) ? osum - DB_W : osum;
    addr  = s1_base + AW'(owrap);
  end

  always_comb begin
    nxt = cur;
    dwe = 1'b0;
    mrd = 1'b0;
    mwr = 1'b0;
    rb  = 8'h00;
    case (s1_op)
      OP_STATUS: begin
        if (!s1_present) begin
          rb = NO_DRIVE_BYTE;
        end else if (cur.trk != 7'd0) begin
          rb = STAT_TRACK_NZ;
        end
      end
      OP_FUNC: begin
        if (s1_present) begin
          dwe = s1_vld;
          if (s1_data[FN_STEP_IN]) begin
            if (cur.trk == TRK_LAST) begin
              nxt.trk   = 7'd0;
              nxt.tbase = '0;
            end else begin
              nxt.trk   = cur.trk + 7'd1;
              nxt.tbase = cur.tbase + TB_STEP;
            end
          end
          if (s1_data[FN_STEP_OUT] && nxt.trk != 7'd0) begin
            nxt.trk   = nxt.trk - 7'd1;
            nxt.tbase = nxt.tbase - TB_STEP;
          end
          if (s1_data[FN_WR_ENABLE]) begin
            nxt.pos  = 16'd0;
            nxt.pmod = '0;
          end
        end
      end
      OP_SECTOR: begin
        if (s1_present) begin
          dwe = s1_vld;
          if (cur.sec == SEC_LAST) begin
            nxt.sec   = 5'd0;
            nxt.sbase = '0;
          end else begin
            nxt.sec   = cur.sec + 5'd1;
            nxt.sbase = cur.sbase + SB_STEP;
          end
          nxt.pos  = 16'd0;
          nxt.pmod = '0;
          rb       = {2'b00, nxt.sec, 1'b0};
        end else begin
          rb = NO_DRIVE_BYTE;
        end
      end
      OP_DREAD, OP_DWRITE: begin
        if (s1_present) begin
          dwe     = s1_vld;
          mrd     = (s1_op == OP_DREAD);
          mwr     = (s1_op == OP_DWRITE);
          nxt.pos = cur.pos + 16'd1;
          // position wraps at 16 bits, which also resets its residue
          if (cur.pos == 16'hFFFF || cur.pmod == DB_LAST) begin
            nxt.pmod = '0;
          end else begin
            nxt.pmod = cur.pmod + OW'(1);
          end
        end else if (s1_op == OP_DREAD) begin
          rb = NO_DRIVE_BYTE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      fwd_vld <= 1'b0;
      req.vld <= 1'b0;
    end else begin
      if (dwe) begin
        vld[s1_idx] <= 1'b1;
      end
      fwd_vld <= dwe;
      req.vld <= s1_vld;
    end
    fwd_idx   <= s1_idx;
    fwd_data  <= nxt;
    req.mrd   <= mrd;
    req.mwr   <= mwr;
    req.rbyte <= rb;
    req.wbyte <= s1_data;
    req_addr  <= addr;
  end

endmodule

@@ design/fdc_ofifo.sv @@
// Result queue between the pipeline and the output channel.
module fdc_ofifo import fdc_pkg::*; #(
  parameter int DEPTH = OQ_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] din,
  input  logic       pop,
  output logic       nonempty,
  output logic [7:0] dout
);

  localparam int PW = wbits(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  logic [7:0]    mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] cnt;

  assign nonempty = (cnt != '0);
  assign dout     = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + CW'(1);
        2'b01:   cnt <= cnt - CW'(1);
        default: cnt <= cnt;
      endcase
    end
    if (push) begin
      mem[wptr] <= din;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> cnt != CW'(DEPTH))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> cnt != '0)
    else $error("result queue underflow");

endmodule

@@ design/floppy_disk_controller_core.sv @@
// Floppy disk controller core: handshake, drive select, disk image stage, result queue.
//
// Usage: each item on the input channel (in_valid/in_ready, operation, bus_data) is one
// processor bus access: select write, status read, function write, sector read, data
// read or data write. Every accepted item yields exactly one item on the output channel
// (out_valid/out_ready, read_data), in order; writes return 0.
// out_valid rises once the item has passed the drive state stage registers, the disk
// request register and the result register into the queue. One item per cycle is
// sustained while in_ready is high: the drive state RAM is read at acceptance, updated
// and written back in the next cycle (with a bypass for back-to-back items on the same
// drive), and the disk image RAM is accessed in the cycle after that.
// Results collect in an 8-entry queue; in_ready drops only while 8 items are accepted
// but not yet delivered, so a stalled receiver backs up into the input after that.
// Reset selects drive 0 and makes every drive read as track 0, sector 0, position 0;
// the disk image content is undefined until written. No clearing pass is needed.
module floppy_disk_controller_core import fdc_pkg::*; #(
  parameter int DRIVES       = DRIVES_DEF,
  parameter int TRACKS       = TRACKS_DEF,
  parameter int SECTORS      = SECTORS_DEF,
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] operation,
  input  logic [7:0] bus_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data
);

  localparam int DB    = TRACKS * SECTORS * SECTOR_BYTES;
  localparam int STORE = DRIVES * DB;
  localparam int AW    = wbits(STORE);
  localparam int OCC_W = $clog2(OQ_DEPTH + 1);

  logic             in_acc;
  logic             out_acc;
  logic [3:0]       sel;
  logic [AW-1:0]    sel_base;
  logic [OCC_W-1:0] occ;
  disk_req_t        req;
  logic [AW-1:0]    req_addr;
  logic [7:0]       disk_q;
  logic             s3_vld;
  logic             s3_mrd;
  logic [7:0]       s3_byte;

  assign in_acc   = in_valid & in_ready;
  assign out_acc  = out_valid & out_ready;
  assign in_ready = (occ != OCC_W'(OQ_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      sel      <= 4'd0;
      sel_base <= '0;
    end else if (in_acc && op_t'(operation) == OP_SELECT && !bus_data[SEL_IGNORE_BIT]) begin
      sel      <= bus_data[3:0];
      sel_base <= AW'(32'(bus_data[3:0]) * 32'(DB));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   occ <= occ + OCC_W'(1);
        2'b01:   occ <= occ - OCC_W'(1);
        default: occ <= occ;
      endcase
    end
  end

  fdc_drv #(
    .DRIVES       (DRIVES),
    .TRACKS       (TRACKS),
    .SECTORS      (SECTORS),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_drv (
    .clk      (clk),
    .rst      (rst),
    .acc      (in_acc),
    .op       (op_t'(operation)),
    .data     (bus_data),
    .sel      (sel),
    .base     (sel_base),
    .req      (req),
    .req_addr (req_addr)
  );

  fdc_ram #(
    .WIDTH (8),
    .DEPTH (STORE)
  ) u_disk (
    .clk   (clk),
    .we    (req.vld & req.mwr),
    .waddr (req_addr),
    .wdata (req.wbyte),
    .raddr (req_addr),
    .rdata (disk_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= req.vld;
    end
    s3_mrd  <= req.mrd;
    s3_byte <= req.rbyte;
  end

  fdc_ofifo #(
    .DEPTH (OQ_DEPTH)
  ) u_ofifo (
    .clk      (clk),
    .rst      (rst),
    .push     (s3_vld),
    .din      (s3_mrd ? disk_q : s3_byte),
    .pop      (out_acc),
    .nonempty (out_valid),
    .dout     (read_data)
  );

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(OQ_DEPTH))
    else $error("items in flight above queue depth");

  a_out_has_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occ != '0)
    else $error("result shown with no item in flight");

  a_stage_order: assert property (@(posedge clk) disable iff (rst)
    s3_vld |-> $past(req.vld))
    else $error("disk stage result without a request");

endmodule
